/* rtl/qoi_pkg.sv */
// Shared types, constants and the palette hash of the QOI stream decoder.
package qoi_pkg;

  localparam int CHAN_W         = 8;
  localparam int PIXEL_W        = 4 * CHAN_W;
  localparam int SLOT_W         = 6;
  localparam int PALETTE_DEPTH  = 1 << SLOT_W;
  localparam int RUN_W          = 6;
  localparam int PEND_W         = 3;
  localparam int COUNT_W        = 32;
  localparam int FIFO_DEPTH_DEF = 4;

  localparam logic [CHAN_W-1:0]  TAG_RGB      = 8'hfe;
  localparam logic [CHAN_W-1:0]  TAG_RGBA     = 8'hff;
  localparam logic [1:0]         OP_INDEX     = 2'b00;
  localparam logic [1:0]         OP_DIFF      = 2'b01;
  localparam logic [1:0]         OP_LUMA      = 2'b10;
  localparam logic [1:0]         OP_RUN       = 2'b11;
  localparam logic [PEND_W-1:0]  PEND_RGB     = 3'd3;
  localparam logic [PEND_W-1:0]  PEND_RGBA    = 3'd4;
  localparam logic [PEND_W-1:0]  PEND_LUMA    = 3'd1;
  localparam logic [PIXEL_W-1:0] PIXEL_RESET  = 32'h0000_00ff;
  localparam logic [CHAN_W-1:0]  DIFF_BIAS    = 8'd2;
  localparam logic [CHAN_W-1:0]  LUMA_BIAS_G  = 8'd32;
  localparam logic [CHAN_W-1:0]  LUMA_BIAS_RB = 8'd40;

  typedef enum logic [2:0] {
    KIND_RGB,
    KIND_RGBA,
    KIND_INDEX,
    KIND_DIFF,
    KIND_LUMA,
    KIND_RUN
  } chunk_kind_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_FETCH,
    B_CALC,
    B_WRITE,
    B_EMIT
  } back_state_t;

  typedef struct packed {
    logic               clear;
    logic               emit;
    chunk_kind_t        kind;
    logic [CHAN_W-1:0]  tag;
    logic [PIXEL_W-1:0] collect;
    logic [RUN_W-1:0]   count;
    logic               done;
  } chunk_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic              last_of_run;
    logic              image_done;
  } pixel_out_t;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [PIXEL_W-1:0] px);
    logic [SLOT_W-1:0] r;
    logic [SLOT_W-1:0] g;
    logic [SLOT_W-1:0] b;
    logic [SLOT_W-1:0] a;
    logic [SLOT_W-1:0] s;
    r = px[3*CHAN_W +: SLOT_W];
    g = px[2*CHAN_W +: SLOT_W];
    b = px[CHAN_W +: SLOT_W];
    a = px[0 +: SLOT_W];
    s = r * 6'd3 + g * 6'd5 + b * 6'd7 + a * 6'd11;
    return s;
  endfunction

endpackage

/* rtl/qoi_stream_decoder.sv */
// QOI chunk-stream decoder: top level joining front end, chunk queue and back end.
//
// Input: one stream byte per beat (data_byte, first_byte set on the first byte
// of an image after its header), taken when push is high and full is low.
// Output: one pixel per beat (red, green, blue, alpha, last_of_run,
// image_done), offered while empty is low and taken when pop is high.
// Configuration: cfg_write loads cfg_data into the pixel limit (width times
// height) at once; write it only between images.
// The front end takes one byte every cycle while its chunk queue has room.
// Each pixel-producing chunk takes the back end through queue pop, palette
// read, pixel build and palette write, then through one emission per pixel;
// the back end takes no new chunk until the last pixel of a run is emitted.
// A stalled receiver holds the pixel on the ports; the back end waits and the
// queue fills, after which full rises and input bytes are held off.
// Reset clears the queue, the pixel limit (no output until it is written), the
// previous pixel to opaque black and the palette valid bits; no clearing pass.
module qoi_stream_decoder #(
  parameter int FIFO_DEPTH = qoi_pkg::FIFO_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [qoi_pkg::CHAN_W-1:0]  data_byte,
  input  logic                        first_byte,
  output logic                        empty,
  input  logic                        pop,
  output logic [qoi_pkg::CHAN_W-1:0]  red,
  output logic [qoi_pkg::CHAN_W-1:0]  green,
  output logic [qoi_pkg::CHAN_W-1:0]  blue,
  output logic [qoi_pkg::CHAN_W-1:0]  alpha,
  output logic                        last_of_run,
  output logic                        image_done,
  input  logic                        cfg_write,
  input  logic [qoi_pkg::COUNT_W-1:0] cfg_data
);

  qoi_pkg::chunk_t     fq_entry, fq_head;
  qoi_pkg::pixel_out_t out_pixel;
  logic                fq_push, fq_pop, fq_full, fq_empty, out_valid;

  qoi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .data_byte (data_byte),
    .first_byte(first_byte),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .fq_full   (fq_full),
    .fq_push   (fq_push),
    .fq_entry  (fq_entry)
  );

  qoi_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (fq_push),
    .push_data(fq_entry),
    .pop      (fq_pop),
    .head     (fq_head),
    .full     (fq_full),
    .empty    (fq_empty)
  );

  qoi_back u_back (
    .clk      (clk),
    .rst      (rst),
    .fq_empty (fq_empty),
    .fq_head  (fq_head),
    .fq_pop   (fq_pop),
    .pop      (pop),
    .out_valid(out_valid),
    .out_pixel(out_pixel)
  );

  assign full        = fq_full;
  assign empty       = !out_valid;
  assign red         = out_pixel.red;
  assign green       = out_pixel.green;
  assign blue        = out_pixel.blue;
  assign alpha       = out_pixel.alpha;
  assign last_of_run = out_pixel.last_of_run;
  assign image_done  = out_pixel.image_done;

endmodule

/* rtl/qoi_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module qoi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/qoi_front.sv */
// Front end: byte intake, chunk collection, classification and pixel counting.
module qoi_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic [qoi_pkg::CHAN_W-1:0]      data_byte,
  input  logic                            first_byte,
  input  logic                            cfg_write,
  input  logic [qoi_pkg::COUNT_W-1:0]     cfg_data,
  input  logic                            fq_full,
  output logic                            fq_push,
  output qoi_pkg::chunk_t                 fq_entry
);

  logic [qoi_pkg::COUNT_W-1:0] pixel_limit;
  logic [qoi_pkg::PIXEL_W-1:0] collect, collect_next, collect_eff;
  logic [qoi_pkg::PEND_W-1:0]  pending, pending_next, pending_eff;
  logic [qoi_pkg::CHAN_W-1:0]  tag, tag_next, tag_eff;
  logic [qoi_pkg::COUNT_W-1:0] emitted, emitted_next, emitted_eff;
  logic                        accept;
  logic                        live;
  logic                        complete;
  logic [qoi_pkg::CHAN_W-1:0]  ctag;
  logic [qoi_pkg::PIXEL_W-1:0] ccollect;
  qoi_pkg::chunk_kind_t        kind;
  logic [qoi_pkg::RUN_W-1:0]   n_raw, n_clip;
  logic [qoi_pkg::COUNT_W-1:0] left;

  assign accept      = push && !fq_full;
  assign pending_eff = first_byte ? '0 : pending;
  assign emitted_eff = first_byte ? '0 : emitted;
  assign collect_eff = first_byte ? '0 : collect;
  assign tag_eff     = first_byte ? '0 : tag;
  assign live        = emitted_eff < pixel_limit;

  always_comb begin
    collect_next = collect_eff;
    pending_next = pending_eff;
    tag_next     = tag_eff;
    complete     = 1'b0;
    ctag         = data_byte;
    ccollect     = '0;
    if (live) begin
      if (pending_eff == '0) begin
        tag_next     = data_byte;
        collect_next = '0;
        if (data_byte == qoi_pkg::TAG_RGB) begin
          pending_next = qoi_pkg::PEND_RGB;
        end else if (data_byte == qoi_pkg::TAG_RGBA) begin
          pending_next = qoi_pkg::PEND_RGBA;
        end else if (data_byte[7:6] == qoi_pkg::OP_LUMA) begin
          pending_next = qoi_pkg::PEND_LUMA;
        end else begin
          complete = 1'b1;
        end
      end else begin
        collect_next = {collect_eff[qoi_pkg::PIXEL_W-qoi_pkg::CHAN_W-1:0], data_byte};
        pending_next = pending_eff - 1'b1;
        complete     = (pending_eff == qoi_pkg::PEND_LUMA);
        ctag         = tag_eff;
        ccollect     = collect_next;
      end
    end
  end

  always_comb begin
    if (ctag == qoi_pkg::TAG_RGB) begin
      kind = qoi_pkg::KIND_RGB;
    end else if (ctag == qoi_pkg::TAG_RGBA) begin
      kind = qoi_pkg::KIND_RGBA;
    end else begin
      case (ctag[7:6])
        qoi_pkg::OP_INDEX: kind = qoi_pkg::KIND_INDEX;
        qoi_pkg::OP_DIFF:  kind = qoi_pkg::KIND_DIFF;
        qoi_pkg::OP_LUMA:  kind = qoi_pkg::KIND_LUMA;
        default:           kind = qoi_pkg::KIND_RUN;
      endcase
    end
  end

  assign n_raw  = (kind == qoi_pkg::KIND_RUN) ? ctag[qoi_pkg::RUN_W-1:0] + 1'b1
                                              : qoi_pkg::RUN_W'(1);
  assign left   = pixel_limit - emitted_eff;
  assign n_clip = (left < qoi_pkg::COUNT_W'(n_raw)) ? left[qoi_pkg::RUN_W-1:0] : n_raw;

  always_comb begin
    emitted_next = emitted_eff;
    if (complete) begin
      emitted_next = emitted_eff + qoi_pkg::COUNT_W'(n_clip);
    end
  end

  assign fq_push          = accept && (first_byte || complete);
  assign fq_entry.clear   = first_byte;
  assign fq_entry.emit    = complete;
  assign fq_entry.kind    = kind;
  assign fq_entry.tag     = ctag;
  assign fq_entry.collect = ccollect;
  assign fq_entry.count   = n_clip;
  assign fq_entry.done    = (qoi_pkg::COUNT_W'(n_clip) == left);

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_limit <= '0;
      collect     <= '0;
      pending     <= '0;
      tag         <= '0;
      emitted     <= '0;
    end else begin
      if (cfg_write) begin
        pixel_limit <= cfg_data;
      end
      if (accept) begin
        collect <= collect_next;
        pending <= pending_next;
        tag     <= tag_next;
        emitted <= emitted_next;
      end
    end
  end

endmodule

/* rtl/qoi_fifo.sv */
// Short chunk queue between the front end and the pixel back end.
module qoi_fifo #(
  parameter int DEPTH = qoi_pkg::FIFO_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  qoi_pkg::chunk_t push_data,
  input  logic            pop,
  output qoi_pkg::chunk_t head,
  output logic            full,
  output logic            empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  qoi_pkg::chunk_t   slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  fill;
  logic              do_push, do_pop;

  assign full    = (fill == CNT_W'(DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

/* rtl/qoi_back.sv */
// Back end: pixel reconstruction, palette upkeep and pixel output register.
module qoi_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                fq_empty,
  input  qoi_pkg::chunk_t     fq_head,
  output logic                fq_pop,
  input  logic                pop,
  output logic                out_valid,
  output qoi_pkg::pixel_out_t out_pixel
);

  localparam int CW = qoi_pkg::CHAN_W;

  qoi_pkg::back_state_t state, state_next;
  qoi_pkg::chunk_t      entry;
  logic [qoi_pkg::PIXEL_W-1:0]       prev, px, px_calc, ram_q;
  logic [qoi_pkg::RUN_W-1:0]         count;
  logic [qoi_pkg::PALETTE_DEPTH-1:0] valid;
  logic                              ram_we;
  logic                              load;
  logic [CW-1:0] pr, pg, pb, pa, dg;
  logic [CW-1:0] cr, cb;

  assign pr = prev[3*CW +: CW];
  assign pg = prev[2*CW +: CW];
  assign pb = prev[CW +: CW];
  assign pa = prev[0 +: CW];
  assign dg = CW'(entry.tag[5:0]);
  assign cr = CW'(entry.collect[7:4]);
  assign cb = CW'(entry.collect[3:0]);

  qoi_ram #(
    .WIDTH(qoi_pkg::PIXEL_W),
    .DEPTH(qoi_pkg::PALETTE_DEPTH)
  ) u_palette (
    .clk  (clk),
    .we   (ram_we),
    .waddr(qoi_pkg::slot_of(px)),
    .wdata(px),
    .raddr(entry.tag[qoi_pkg::SLOT_W-1:0]),
    .rdata(ram_q)
  );

  always_comb begin
    case (entry.kind)
      qoi_pkg::KIND_RGB:   px_calc = {entry.collect[3*CW-1:0], pa};
      qoi_pkg::KIND_RGBA:  px_calc = entry.collect;
      qoi_pkg::KIND_INDEX: px_calc = valid[entry.tag[qoi_pkg::SLOT_W-1:0]] ? ram_q : '0;
      qoi_pkg::KIND_DIFF:  px_calc = {pr + CW'(entry.tag[5:4]) - qoi_pkg::DIFF_BIAS,
                                      pg + CW'(entry.tag[3:2]) - qoi_pkg::DIFF_BIAS,
                                      pb + CW'(entry.tag[1:0]) - qoi_pkg::DIFF_BIAS,
                                      pa};
      qoi_pkg::KIND_LUMA:  px_calc = {pr + dg + cr - qoi_pkg::LUMA_BIAS_RB,
                                      pg + dg - qoi_pkg::LUMA_BIAS_G,
                                      pb + dg + cb - qoi_pkg::LUMA_BIAS_RB,
                                      pa};
      default:             px_calc = prev;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      qoi_pkg::B_IDLE: begin
        if (!fq_empty && fq_head.emit) begin
          state_next = qoi_pkg::B_FETCH;
        end
      end
      qoi_pkg::B_FETCH: state_next = qoi_pkg::B_CALC;
      qoi_pkg::B_CALC:  state_next = qoi_pkg::B_WRITE;
      qoi_pkg::B_WRITE: state_next = qoi_pkg::B_EMIT;
      qoi_pkg::B_EMIT: begin
        if (load && count == qoi_pkg::RUN_W'(1)) begin
          state_next = qoi_pkg::B_IDLE;
        end
      end
      default: state_next = qoi_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    fq_pop = 1'b0;
    ram_we = 1'b0;
    load   = 1'b0;
    case (state)
      qoi_pkg::B_IDLE:  fq_pop = !fq_empty;
      qoi_pkg::B_WRITE: ram_we = 1'b1;
      qoi_pkg::B_EMIT:  load   = !out_valid || pop;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= qoi_pkg::B_IDLE;
      valid     <= '0;
      prev      <= qoi_pkg::PIXEL_RESET;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fq_pop && fq_head.clear) begin
        valid <= '0;
        prev  <= qoi_pkg::PIXEL_RESET;
      end
      if (state == qoi_pkg::B_CALC) begin
        prev  <= px_calc;
        count <= entry.count;
      end
      if (ram_we) begin
        valid[qoi_pkg::slot_of(px)] <= 1'b1;
      end
      if (load) begin
        count     <= count - 1'b1;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fq_pop) begin
      entry <= fq_head;
    end
    if (state == qoi_pkg::B_CALC) begin
      px <= px_calc;
    end
    if (load) begin
      out_pixel.red         <= px[3*CW +: CW];
      out_pixel.green       <= px[2*CW +: CW];
      out_pixel.blue        <= px[CW +: CW];
      out_pixel.alpha       <= px[0 +: CW];
      out_pixel.last_of_run <= (count == qoi_pkg::RUN_W'(1));
      out_pixel.image_done  <= entry.done && (count == qoi_pkg::RUN_W'(1));
    end
  end

  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    (state == qoi_pkg::B_EMIT) |-> (count != '0))
    else $error("pixel emission with zero count");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_pixel.image_done) |-> out_pixel.last_of_run)
    else $error("image end not on last pixel of a chunk");

  a_write_then_emit: assert property (@(posedge clk) disable iff (rst)
    (state == qoi_pkg::B_WRITE) |=> (state == qoi_pkg::B_EMIT))
    else $error("palette write not followed by emission");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    fq_pop |-> (state == qoi_pkg::B_IDLE && !fq_empty))
    else $error("chunk taken outside idle");

endmodule
